// ===== rtl/prthc_pkg.sv =====
package prthc_pkg;

   // number formats
   localparam int COORD_W         = 32;
   localparam int COORD_FRAC_BITS = 16;
   localparam int COEF_W          = 16;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int ROW_W           = 3 * COEF_W;
   localparam int PROD_W          = COORD_W + COEF_W;
   localparam int SUM_W           = PROD_W + 2;
   localparam int SHIFT_W         = SUM_W - COEF_FRAC_BITS;
   localparam int RES_W           = SHIFT_W + 1;
   localparam int COLOR_W         = 8;
   localparam int BAND_W          = 4;

   // register map, 8-byte stride
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_Z = 3'd5;

   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);
   localparam logic [ROW_W-1:0]  ROT_X_RESET = {{(2*COEF_W){1'b0}}, COEF_ONE};
   localparam logic [ROW_W-1:0]  ROT_Y_RESET = {{COEF_W{1'b0}}, COEF_ONE, {COEF_W{1'b0}}};
   localparam logic [ROW_W-1:0]  ROT_Z_RESET = {COEF_ONE, {(2*COEF_W){1'b0}}};

   // height thresholds, millimeters rounded to nearest coordinate step
   localparam logic signed [COORD_W-1:0] BAND_T5  =
      COORD_W'(((5 << COORD_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COORD_W-1:0] BAND_T10 =
      COORD_W'(((10 << COORD_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COORD_W-1:0] BAND_T15 =
      COORD_W'(((15 << COORD_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COORD_W-1:0] BAND_T20 =
      COORD_W'(((20 << COORD_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COORD_W-1:0] BAND_T30 =
      COORD_W'(((30 << COORD_FRAC_BITS) + 500) / 1000);

   localparam logic [BAND_W-1:0] BAND_BLUE    = 4'd0;
   localparam logic [BAND_W-1:0] BAND_GREEN   = 4'd1;
   localparam logic [BAND_W-1:0] BAND_RED     = 4'd2;
   localparam logic [BAND_W-1:0] BAND_CYAN    = 4'd3;
   localparam logic [BAND_W-1:0] BAND_YELLOW  = 4'd4;
   localparam logic [BAND_W-1:0] BAND_MAGENTA = 4'd5;
   localparam logic [BAND_W-1:0] BAND_BLACK   = 4'd6;
   localparam logic [BAND_W-1:0] BAND_TEAL    = 4'd7;
   localparam logic [BAND_W-1:0] BAND_OCHRE   = 4'd8;
   localparam logic [BAND_W-1:0] BAND_BROWN   = 4'd9;
   localparam logic [BAND_W-1:0] BAND_WHITE   = 4'd10;

   typedef struct packed {
      logic [2:0][ROW_W-1:0]   rot;
      logic [2:0][COORD_W-1:0] trans;
   } cfg_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] pt;
      logic                    last;
   } point_type;

   typedef struct packed {
      logic [8:0][PROD_W-1:0] prod;
      logic                   last;
   } prod_type;

   typedef struct packed {
      logic [2:0][SHIFT_W-1:0] row;
      logic                    last;
   } row_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] pt;
      logic                    clip;
      logic                    last;
   } sat_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] pt;
      logic [COLOR_W-1:0]      red;
      logic [COLOR_W-1:0]      green;
      logic [COLOR_W-1:0]      blue;
      logic [BAND_W-1:0]       band;
      logic                    clip;
      logic                    last;
   } rsp_type;

   // {red, green, blue}
   function automatic logic [3*COLOR_W-1:0] band_color(input logic [BAND_W-1:0] band);
      logic [3*COLOR_W-1:0] rgb;
      case (band)
         BAND_BLUE:    rgb = {8'd0,   8'd0,   8'd255};
         BAND_GREEN:   rgb = {8'd0,   8'd255, 8'd0};
         BAND_RED:     rgb = {8'd255, 8'd0,   8'd0};
         BAND_CYAN:    rgb = {8'd0,   8'd255, 8'd255};
         BAND_YELLOW:  rgb = {8'd255, 8'd255, 8'd0};
         BAND_MAGENTA: rgb = {8'd255, 8'd0,   8'd255};
         BAND_BLACK:   rgb = {8'd0,   8'd0,   8'd0};
         BAND_TEAL:    rgb = {8'd3,   8'd168, 8'd158};
         BAND_OCHRE:   rgb = {8'd199, 8'd97,  8'd20};
         BAND_BROWN:   rgb = {8'd128, 8'd42,  8'd42};
         default:      rgb = {8'd255, 8'd255, 8'd255};
      endcase
      return rgb;
   endfunction

endpackage

// ===== rtl/prthc_csr.sv =====
module prthc_csr
   import prthc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [ROW_W-1:0]   rot_x_ff, rot_y_ff, rot_z_ff;
   logic [COORD_W-1:0] trans_x_ff, trans_y_ff, trans_z_ff;
   logic               wr_en;
   logic [CSR_IDX_W-1:0] idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff   <= ROT_X_RESET;
         rot_y_ff   <= ROT_Y_RESET;
         rot_z_ff   <= ROT_Z_RESET;
         trans_x_ff <= '0;
         trans_y_ff <= '0;
         trans_z_ff <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_ROT_X:   rot_x_ff   <= csr_pwdata[ROW_W-1:0];
            REG_ROT_Y:   rot_y_ff   <= csr_pwdata[ROW_W-1:0];
            REG_ROT_Z:   rot_z_ff   <= csr_pwdata[ROW_W-1:0];
            REG_TRANS_X: trans_x_ff <= csr_pwdata[COORD_W-1:0];
            REG_TRANS_Y: trans_y_ff <= csr_pwdata[COORD_W-1:0];
            REG_TRANS_Z: trans_z_ff <= csr_pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ROT_X:   csr_prdata = {{(CSR_DATA_W-ROW_W){1'b0}}, rot_x_ff};
         REG_ROT_Y:   csr_prdata = {{(CSR_DATA_W-ROW_W){1'b0}}, rot_y_ff};
         REG_ROT_Z:   csr_prdata = {{(CSR_DATA_W-ROW_W){1'b0}}, rot_z_ff};
         REG_TRANS_X: csr_prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, trans_x_ff};
         REG_TRANS_Y: csr_prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, trans_y_ff};
         REG_TRANS_Z: csr_prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, trans_z_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign cfg.rot   = {rot_z_ff, rot_y_ff, rot_x_ff};
   assign cfg.trans = {trans_z_ff, trans_y_ff, trans_x_ff};

endmodule

// ===== rtl/prthc_mul.sv =====
module prthc_mul
   import prthc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      up_valid,
   output logic      up_ready,
   input  point_type up_data,
   output logic      dn_valid,
   input  logic      dn_ready,
   output prod_type  dn_data
);

   logic     valid_ff, valid_in;
   prod_type data_ff, data_in;

   // nine independent 16x32 products, prod[3*row + col]
   always_comb begin
      data_in.last = up_data.last;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            data_in.prod[3*r+c] =
               PROD_W'($signed(cfg.rot[r][COEF_W*c +: COEF_W]))
               * PROD_W'($signed(up_data.pt[c]));
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/prthc_sum.sv =====
module prthc_sum
   import prthc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  prod_type up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output row_type  dn_data
);

   logic              valid_ff, valid_in;
   row_type           data_ff, data_in;
   logic [SUM_W-1:0]  sum [3];

   // row sum, then floor shift = drop the low fraction bits
   always_comb begin
      data_in.last = up_data.last;
      for (int r = 0; r < 3; r++) begin
         sum[r] = {{(SUM_W-PROD_W){up_data.prod[3*r][PROD_W-1]}},   up_data.prod[3*r]}
                + {{(SUM_W-PROD_W){up_data.prod[3*r+1][PROD_W-1]}}, up_data.prod[3*r+1]}
                + {{(SUM_W-PROD_W){up_data.prod[3*r+2][PROD_W-1]}}, up_data.prod[3*r+2]};
         data_in.row[r] = sum[r][SUM_W-1:COEF_FRAC_BITS];
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/prthc_sat.sv =====
module prthc_sat
   import prthc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    up_valid,
   output logic    up_ready,
   input  row_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output sat_type dn_data
);

   localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   logic              valid_ff, valid_in;
   sat_type           data_ff, data_in;
   logic [RES_W-1:0]  res [3];
   logic [RES_W-COORD_W:0] top [3];
   logic [2:0]        ovf;

   always_comb begin
      data_in.last = up_data.last;
      for (int r = 0; r < 3; r++) begin
         res[r] = {up_data.row[r][SHIFT_W-1], up_data.row[r]}
                + {{(RES_W-COORD_W){cfg.trans[r][COORD_W-1]}}, cfg.trans[r]};
         // in range only if the bits above bit 30 all match
         top[r] = res[r][RES_W-1:COORD_W-1];
         ovf[r] = (top[r] != '0) && (top[r] != '1);
         if (!ovf[r]) begin
            data_in.pt[r] = res[r][COORD_W-1:0];
         end else if (res[r][RES_W-1]) begin
            data_in.pt[r] = COORD_MIN;
         end else begin
            data_in.pt[r] = COORD_MAX;
         end
      end
      data_in.clip = |ovf;
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/prthc_band.sv =====
module prthc_band
   import prthc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  sat_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output rsp_type dn_data
);

   logic                        valid_ff, valid_in;
   rsp_type                     data_ff, data_in;
   logic signed [COORD_W-1:0]   y;
   logic [BAND_W-1:0]           band;

   assign y = $signed(up_data.pt[1]);

   // first match wins; zero height is blue
   always_comb begin
      if (y <= 0 && y >= -BAND_T5) begin
         band = BAND_BLUE;
      end else if (y < -BAND_T5 && y >= -BAND_T10) begin
         band = BAND_GREEN;
      end else if (y < -BAND_T10 && y >= -BAND_T15) begin
         band = BAND_RED;
      end else if (y < -BAND_T15 && y >= -BAND_T20) begin
         band = BAND_CYAN;
      end else if (y < -BAND_T20 && y >= -BAND_T30) begin
         band = BAND_YELLOW;
      end else if (y < -BAND_T30) begin
         band = BAND_MAGENTA;
      end else if (y < BAND_T5) begin
         band = BAND_BLACK;
      end else if (y < BAND_T10) begin
         band = BAND_TEAL;
      end else if (y < BAND_T15) begin
         band = BAND_OCHRE;
      end else if (y < BAND_T20) begin
         band = BAND_BROWN;
      end else begin
         band = BAND_WHITE;
      end
   end

   always_comb begin
      data_in.pt   = up_data.pt;
      {data_in.red, data_in.green, data_in.blue} = band_color(band);
      data_in.band = band;
      data_in.clip = up_data.clip;
      data_in.last = up_data.last;
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/point_rigid_transform_height_colorize_unit.sv =====
// Pipeline stages from req accept to rsp_tvalid: multiply, row sum, translate
//   and saturate, band lookup; the band stage is the output register.
// Throughput: one item per cycle while the output is not stalled; each stage holds its item while downstream
//   stalls and takes a new one as soon as it empties, so bubbles close up.
// Reset: synchronous, active high; clears all stage valid bits and loads the
//   identity rotation and zero translation.
module point_rigid_transform_height_colorize_unit
   import prthc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // input points
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*COORD_W-1:0]  req_tdata,   // point_x, point_y, point_z
   input  logic                  req_tlast,   // last_in

   // transformed, colored points
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,   // out_x, out_y, out_z, color_red,
                                              // color_green, color_blue, band_index,
                                              // saturated, 3 zero bits
   output logic                  rsp_tlast,   // last_out

   // register port, 8-byte stride
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type   cfg;
   point_type req_pt;
   prod_type  prod_data;
   row_type   row_data;
   sat_type   sat_data;
   rsp_type   rsp_data;
   logic      prod_valid, prod_ready;
   logic      row_valid, row_ready;
   logic      sat_valid, sat_ready;

   // registers feed the datapath directly; the user must change them only while idle, the block does not enforce it
   prthc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_pt.pt   = {req_tdata[3*COORD_W-1:2*COORD_W],
                         req_tdata[2*COORD_W-1:COORD_W],
                         req_tdata[COORD_W-1:0]};
   assign req_pt.last = req_tlast;

   // stage 1: nine coefficient x coordinate products
   prthc_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_data  (req_pt),
      .dn_valid (prod_valid),
      .dn_ready (prod_ready),
      .dn_data  (prod_data)
   );

   // stage 2: three-term row sums, floor shift out of the coefficient fraction
   prthc_sum u_sum (
      .clock    (clock),
      .reset    (reset),
      .up_valid (prod_valid),
      .up_ready (prod_ready),
      .up_data  (prod_data),
      .dn_valid (row_valid),
      .dn_ready (row_ready),
      .dn_data  (row_data)
   );

   // stage 3: add translation, clip to 32 bits, flag any clip
   prthc_sat u_sat (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (row_valid),
      .up_ready (row_ready),
      .up_data  (row_data),
      .dn_valid (sat_valid),
      .dn_ready (sat_ready),
      .dn_data  (sat_data)
   );

   // stage 4: height band from transformed y, color lookup; output register
   prthc_band u_band (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sat_valid),
      .up_ready (sat_ready),
      .up_data  (sat_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_data  (rsp_data)
   );

   assign rsp_tdata = {3'b000, rsp_data.clip, rsp_data.band,
                       rsp_data.blue, rsp_data.green, rsp_data.red,
                       rsp_data.pt[2], rsp_data.pt[1], rsp_data.pt[0]};
   assign rsp_tlast = rsp_data.last;

endmodule

// ===== rtl/prthc_chk.sv =====
module prthc_chk
   import prthc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tlast
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_band_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[123:120] <= BAND_WHITE)
      else $error("band index out of range");

   // zero height lands in the blue band; bits 119:96 are {blue, green, red}
   a_zero_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[63:32] == '0 |->
         rsp_tdata[123:120] == BAND_BLUE && rsp_tdata[119:96] == 24'hff0000)
      else $error("zero height not blue");

endmodule

bind point_rigid_transform_height_colorize_unit prthc_chk u_prthc_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
